>>> rtl/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types, constants and helpers of the 3x3 RGB box blur.
// ----------------------------------------------------------------------------
`default_nettype none

package bb3_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int CFG_W_BITS = 11;
    localparam int CFG_H_BITS = 13;
    localparam logic [CFG_W_BITS-1:0] IMAGE_WIDTH_RST  = 11'd1024;
    localparam logic [CFG_H_BITS-1:0] IMAGE_HEIGHT_RST = 13'd768;

    // register index, decoded from paddr[2]
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // item kinds on s_tuser
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    localparam int PIX_BITS   = 24;
    localparam int NROWS      = 3;
    localparam int SUM_BITS   = 12;
    localparam int CNT_BITS   = 4;
    localparam int NUM_BITS   = 13;
    localparam int RECIP_BITS = 18;
    localparam int RECIP_SHIFT = 18;

    typedef struct packed {
        logic [CFG_H_BITS-1:0] image_height;
        logic [CFG_W_BITS-1:0] image_width;
    } cfg_regs_t;

    typedef logic [2:0][SUM_BITS-1:0] sums_t;
    typedef logic [2:0][7:0]          means_t;

    // ceil(2^18 / (2*count)): exact for numerators below 2^13
    function automatic logic [RECIP_BITS-1:0] recip(input logic [CNT_BITS-1:0] count);
        logic [RECIP_BITS-1:0] m;
        case (count)
            4'd1:    m = 18'd131072;
            4'd2:    m = 18'd65536;
            4'd3:    m = 18'd43691;
            4'd4:    m = 18'd32768;
            4'd5:    m = 18'd26215;
            4'd6:    m = 18'd21846;
            4'd7:    m = 18'd18725;
            4'd8:    m = 18'd16384;
            4'd9:    m = 18'd14564;
            default: m = 18'd131072;
        endcase
        return m;
    endfunction

    function automatic logic [1:0] bank_inc(input logic [1:0] b);
        return (b == 2'd2) ? 2'd0 : b + 2'd1;
    endfunction

    function automatic logic [1:0] bank_dec(input logic [1:0] b);
        return (b == 2'd0) ? 2'd2 : b - 2'd1;
    endfunction

endpackage

`default_nettype wire

>>> rtl/bb3_cfg.sv
// ----------------------------------------------------------------------------
// bb3_cfg
// APB register file: image width and height.
// ----------------------------------------------------------------------------
`default_nettype none

module bb3_cfg (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready,
    output bb3_pkg::cfg_regs_t       cfg
);

    bb3_pkg::cfg_regs_t cfg_reg;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width  <= bb3_pkg::IMAGE_WIDTH_RST;
            cfg_reg.image_height <= bb3_pkg::IMAGE_HEIGHT_RST;
        end else if (wr_en) begin
            case (paddr[2])
                bb3_pkg::REG_IMAGE_WIDTH: begin
                    cfg_reg.image_width <= pwdata[bb3_pkg::CFG_W_BITS-1:0];
                end
                bb3_pkg::REG_IMAGE_HEIGHT: begin
                    cfg_reg.image_height <= pwdata[bb3_pkg::CFG_H_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            bb3_pkg::REG_IMAGE_WIDTH:  prdata = 32'(cfg_reg.image_width);
            bb3_pkg::REG_IMAGE_HEIGHT: prdata = 32'(cfg_reg.image_height);
            default:                   prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/bb3_line_mem.sv
// ----------------------------------------------------------------------------
// bb3_line_mem
// Line store: one entry per column, three row lanes, lane write, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bb3_line_mem #(
    parameter int DEPTH = bb3_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                                          aclk,
    input  wire logic                                          we,
    input  wire logic [AW-1:0]                                 wr_addr,
    input  wire logic [1:0]                                    wr_lane,
    input  wire logic [bb3_pkg::PIX_BITS-1:0]                  wr_data,
    input  wire logic                                          rd_en,
    input  wire logic [AW-1:0]                                 rd_addr,
    output logic [bb3_pkg::NROWS-1:0][bb3_pkg::PIX_BITS-1:0]   rd_data
);

    logic [bb3_pkg::NROWS-1:0][bb3_pkg::PIX_BITS-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr][wr_lane] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/bb3_mean.sv
// ----------------------------------------------------------------------------
// bb3_mean
// Rounded mean per channel by reciprocal multiply, product registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bb3_mean (
    input  wire logic                          aclk,
    input  wire logic                          load,
    input  wire bb3_pkg::sums_t                sums,
    input  wire logic [bb3_pkg::CNT_BITS-1:0]  count,
    output bb3_pkg::means_t                    means
);

    localparam int PROD_BITS = bb3_pkg::NUM_BITS + bb3_pkg::RECIP_BITS;

    logic [2:0][PROD_BITS-1:0]         prod_reg;
    logic [2:0][bb3_pkg::NUM_BITS-1:0] num;
    logic [bb3_pkg::RECIP_BITS-1:0]    m;

    always_comb begin
        m = bb3_pkg::recip(count);
        for (int ch = 0; ch < 3; ch++) begin
            num[ch] = {sums[ch], 1'b0} + bb3_pkg::NUM_BITS'(count);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int ch = 0; ch < 3; ch++) begin
                prod_reg[ch] <= PROD_BITS'(num[ch]) * PROD_BITS'(m);
            end
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            means[ch] = prod_reg[ch][bb3_pkg::RECIP_SHIFT +: 8];
        end
    end

endmodule

`default_nettype wire

>>> rtl/box_blur_3x3_rgb_core.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_core
// Streaming 3x3 box blur of RGB pixels, edge-aware divisor, drain after frame.
// Each accepted item causes 0..2 results; each result takes three column reads
//   from the single-read line memory, a multiply and an output load, and no new
//   item is accepted until the last result of the previous one is loaded.
// Reset: synchronous active-low aresetn clears control and position state;
//   the line memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module box_blur_3x3_rgb_core #(
    parameter int MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // input items
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [23:0]  s_tdata,   // red_in, green_in, blue_in
    input  wire logic [0:0]   s_tuser,   // req_type
    // result items
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [23:0]       m_tdata,   // red_out, green_out, blue_out
    output logic [1:0]        m_tuser,   // frame_done, last_of_run
    // configuration
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int CB = bb3_pkg::CNT_BITS;
    localparam int SB = bb3_pkg::SUM_BITS;

    typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_DIV, ST_OUT} state_t;

    bb3_pkg::cfg_regs_t cfg;

    state_t          state_reg;
    logic [CW-1:0]   in_col_reg;
    logic [RW-1:0]   in_row_reg;
    logic [1:0]      in_bank_reg;
    logic            input_done_reg;
    logic [WW-1:0]   frame_w_reg;
    logic [HW-1:0]   frame_h_reg;
    logic [CW-1:0]   out_col_reg;
    logic [RW-1:0]   out_row_reg;
    logic [1:0]      out_bank_reg;
    logic [1:0]      out_left_reg;
    logic [1:0]      rd_step_reg;
    logic            rd_pend_reg;
    logic            col_ok_reg;
    bb3_pkg::sums_t  sum_reg;
    logic [CB-1:0]   cnt_reg;
    logic            m_tvalid_reg;
    logic [23:0]     m_data_reg;
    logic [1:0]      m_user_reg;

    logic            s_accept;
    logic            is_pixel;
    logic            first_px;
    logic [WW-1:0]   cfg_w_clamp;
    logic [HW-1:0]   cfg_h_clamp;
    logic [WW-1:0]   eff_w;
    logic [HW-1:0]   eff_h;
    logic            last_col;
    logic            last_row;
    logic [1:0]      emit_cnt;
    logic            mem_we;
    logic            rd_en;
    logic [CW:0]     rd_col;
    logic            col_ok;
    logic [2:0][23:0] rd_data;
    logic            row_ok_up;
    logic            row_ok_dn;
    logic [CB-1:0]   nrows;
    bb3_pkg::sums_t  col_add;
    bb3_pkg::means_t means;
    logic            final_out;
    logic            out_free;

    bb3_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    always_comb begin
        if (cfg.image_width == '0) begin
            cfg_w_clamp = WW'(1);
        end else if (32'(cfg.image_width) > 32'(MAX_WIDTH)) begin
            cfg_w_clamp = WW'(MAX_WIDTH);
        end else begin
            cfg_w_clamp = WW'(cfg.image_width);
        end
        if (cfg.image_height == '0) begin
            cfg_h_clamp = HW'(1);
        end else if (32'(cfg.image_height) > 32'(MAX_HEIGHT)) begin
            cfg_h_clamp = HW'(MAX_HEIGHT);
        end else begin
            cfg_h_clamp = HW'(cfg.image_height);
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign is_pixel = (s_tuser[0] == bb3_pkg::REQ_PIXEL);
    assign first_px = (in_row_reg == '0) && (in_col_reg == '0);
    assign eff_w    = first_px ? cfg_w_clamp : frame_w_reg;
    assign eff_h    = first_px ? cfg_h_clamp : frame_h_reg;
    assign last_col = (WW'(in_col_reg) == eff_w - WW'(1));
    assign last_row = (HW'(in_row_reg) == eff_h - HW'(1));
    assign mem_we   = s_accept && is_pixel && !input_done_reg;

    always_comb begin
        if (in_row_reg == '0) begin
            emit_cnt = 2'd0;
        end else if (last_col) begin
            emit_cnt = (eff_w == WW'(1)) ? 2'd1 : 2'd2;
        end else begin
            emit_cnt = (in_col_reg != '0) ? 2'd1 : 2'd0;
        end
    end

    // column c-1, c, c+1 of the current output
    assign rd_en  = (state_reg == ST_READ) && (rd_step_reg != 2'd3);
    assign rd_col = {1'b0, out_col_reg} + (CW+1)'(rd_step_reg) - (CW+1)'(1);

    always_comb begin
        case (rd_step_reg)
            2'd0:    col_ok = (out_col_reg != '0);
            2'd1:    col_ok = 1'b1;
            2'd2:    col_ok = (WW'(out_col_reg) + WW'(1) != frame_w_reg);
            default: col_ok = 1'b0;
        endcase
    end

    bb3_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_mem (
        .aclk    (aclk),
        .we      (mem_we),
        .wr_addr (in_col_reg),
        .wr_lane (in_bank_reg),
        .wr_data (s_tdata),
        .rd_en   (rd_en),
        .rd_addr (rd_col[CW-1:0]),
        .rd_data (rd_data)
    );

    assign row_ok_up = (out_row_reg != '0);
    assign row_ok_dn = (HW'(out_row_reg) + HW'(1) != frame_h_reg);
    assign nrows     = CB'(1) + CB'(row_ok_up) + CB'(row_ok_dn);

    always_comb begin
        logic [1:0] b_up;
        logic [1:0] b_dn;
        b_up = bb3_pkg::bank_dec(out_bank_reg);
        b_dn = bb3_pkg::bank_inc(out_bank_reg);
        for (int ch = 0; ch < 3; ch++) begin
            col_add[ch] = SB'(rd_data[out_bank_reg][ch*8 +: 8])
                        + (row_ok_up ? SB'(rd_data[b_up][ch*8 +: 8]) : SB'(0))
                        + (row_ok_dn ? SB'(rd_data[b_dn][ch*8 +: 8]) : SB'(0));
        end
    end

    bb3_mean u_mean (
        .aclk  (aclk),
        .load  (state_reg == ST_DIV),
        .sums  (sum_reg),
        .count (cnt_reg),
        .means (means)
    );

    assign final_out = (WW'(out_col_reg) == frame_w_reg - WW'(1))
                    && (HW'(out_row_reg) == frame_h_reg - HW'(1));
    assign out_free  = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            in_col_reg     <= '0;
            in_row_reg     <= '0;
            in_bank_reg    <= '0;
            input_done_reg <= 1'b0;
            out_col_reg    <= '0;
            out_row_reg    <= '0;
            out_bank_reg   <= '0;
            out_left_reg   <= '0;
            rd_step_reg    <= '0;
            rd_pend_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && (state_reg != ST_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        if (is_pixel && !input_done_reg) begin
                            if (first_px) begin
                                frame_w_reg <= cfg_w_clamp;
                                frame_h_reg <= cfg_h_clamp;
                            end
                            if (last_col) begin
                                in_col_reg <= '0;
                                if (last_row) begin
                                    in_row_reg     <= '0;
                                    in_bank_reg    <= '0;
                                    input_done_reg <= 1'b1;
                                end else begin
                                    in_row_reg  <= in_row_reg + RW'(1);
                                    in_bank_reg <= bb3_pkg::bank_inc(in_bank_reg);
                                end
                            end else begin
                                in_col_reg <= in_col_reg + CW'(1);
                            end
                            if (emit_cnt != 2'd0) begin
                                out_left_reg <= emit_cnt;
                                rd_step_reg  <= 2'd0;
                                state_reg    <= ST_READ;
                            end
                        end else if (!is_pixel && input_done_reg) begin
                            out_left_reg <= 2'd1;
                            rd_step_reg  <= 2'd0;
                            state_reg    <= ST_READ;
                        end
                    end
                end
                ST_READ: begin
                    if (rd_step_reg == 2'd0) begin
                        sum_reg <= '0;
                        cnt_reg <= '0;
                    end else if (rd_pend_reg && col_ok_reg) begin
                        for (int ch = 0; ch < 3; ch++) begin
                            sum_reg[ch] <= sum_reg[ch] + col_add[ch];
                        end
                        cnt_reg <= cnt_reg + nrows;
                    end
                    rd_pend_reg <= (rd_step_reg != 2'd3);
                    col_ok_reg  <= col_ok;
                    rd_step_reg <= rd_step_reg + 2'd1;
                    if (rd_step_reg == 2'd3) begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_data_reg   <= {means[2], means[1], means[0]};
                        m_user_reg   <= {final_out, (out_left_reg == 2'd1)};
                        if (final_out) begin
                            out_col_reg    <= '0;
                            out_row_reg    <= '0;
                            out_bank_reg   <= '0;
                            input_done_reg <= 1'b0;
                        end else if (WW'(out_col_reg) == frame_w_reg - WW'(1)) begin
                            out_col_reg  <= '0;
                            out_row_reg  <= out_row_reg + RW'(1);
                            out_bank_reg <= bb3_pkg::bank_inc(out_bank_reg);
                        end else begin
                            out_col_reg <= out_col_reg + CW'(1);
                        end
                        out_left_reg <= out_left_reg - 2'd1;
                        rd_step_reg  <= 2'd0;
                        state_reg    <= (out_left_reg == 2'd1) ? ST_IDLE : ST_READ;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

`default_nettype wire
